// ===== rtl/core/kvps_pkg.sv =====
// Package for the key-value pair sorter.
// Holds the capacity constant and the transaction, entry and cell control types.
// No dependencies.
package kvps_pkg;

    localparam int MAX_PAIRS = 64;
    localparam int FILL_W    = $clog2(MAX_PAIRS + 1);

    typedef struct packed {
        logic [31:0] pair_key;
        logic [31:0] pair_value;
        logic        last_in;
    } t_in;

    typedef struct packed {
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic        last_out;
        logic        dropped;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic        load;
        logic        unload;
        logic [31:0] key;
        logic [31:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/kvps_cell.sv =====
// One cell of the sorting chain: holds one pair and moves it to a neighbor.
// Depends on kvps_pkg.
module kvps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kvps_pkg::t_cell_ctl i_ctl,
    input  kvps_pkg::t_entry   i_prev_entry,
    input  logic               i_prev_ins,
    input  kvps_pkg::t_entry   i_next_entry,
    output kvps_pkg::t_entry   o_entry,
    output logic               o_ins
);
    import kvps_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // A new pair goes before every held pair with a strictly larger value.
    assign o_ins   = !r_entry.valid || (i_ctl.value < r_entry.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load && o_ins) begin
            if (i_prev_ins) begin
                n_entry = i_prev_entry;
            end else begin
                n_entry = '{valid: 1'b1, key: i_ctl.key, value: i_ctl.value};
            end
        end else if (i_ctl.unload) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.key   <= n_entry.key;
        r_entry.value <= n_entry.value;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

// ===== rtl/core/key_value_pair_sorter.sv =====
// Top level of the key-value pair sorter: a chain of insertion cells and the drain control.
// Depends on kvps_pkg and kvps_cell.
//
//   channel | direction | handshake                 | payload
//   input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in)
//   output  | out       | o_out_valid / i_out_ready | o_out_data (t_out)
//
// Pairs are accepted while the chain is not draining; each cell compares the new value with its own.
// After the closing pair the chain drains one pair per cycle into the output register,
// unless the output stalls, so all N held pairs are drained before the next pair is taken.
// Reset clears all cell valid bits, the fill count and the overflow flag.
// A stalled output holds the drain; pairs beyond capacity are discarded.
module key_value_pair_sorter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kvps_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output kvps_pkg::t_out o_out_data
);
    import kvps_pkg::*;

    logic              r_drain;
    logic [FILL_W-1:0] r_fill;
    logic              r_overflow;
    logic              r_out_valid;
    t_out              r_out;

    t_entry    entries [MAX_PAIRS];
    logic      ins     [MAX_PAIRS];
    t_cell_ctl ctl;
    logic      in_acc;
    logic      full;
    logic      unload;
    logic      final_pair;

    assign o_in_ready  = !r_drain;
    assign in_acc      = i_in_valid && !r_drain;
    assign full        = (r_fill == FILL_W'(MAX_PAIRS));
    assign unload      = r_drain && (!r_out_valid || i_out_ready);
    assign final_pair  = !entries[1].valid;

    assign ctl.load   = in_acc && !full;
    assign ctl.unload = unload;
    assign ctl.key    = i_in_data.pair_key;
    assign ctl.value  = i_in_data.pair_value;

    for (genvar g = 0; g < MAX_PAIRS; g++) begin : g_cell
        t_entry prev_entry;
        t_entry next_entry;
        logic   prev_ins;

        if (g == 0) begin : g_first
            assign prev_entry = '0;
            assign prev_ins   = 1'b0;
        end else begin : g_mid
            assign prev_entry = entries[g-1];
            assign prev_ins   = ins[g-1];
        end

        if (g == MAX_PAIRS - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_rest
            assign next_entry = entries[g+1];
        end

        kvps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_prev_entry (prev_entry),
            .i_prev_ins   (prev_ins),
            .i_next_entry (next_entry),
            .o_entry      (entries[g]),
            .o_ins        (ins[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_fill      <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_fill <= r_fill + FILL_W'(1);
                end
                if (i_in_data.last_in) begin
                    r_drain <= 1'b1;
                end
            end
            if (unload) begin
                r_out_valid <= 1'b1;
                if (final_pair) begin
                    r_drain    <= 1'b0;
                    r_fill     <= '0;
                    r_overflow <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (unload) begin
            r_out.out_key   <= entries[0].key;
            r_out.out_value <= entries[0].value;
            r_out.last_out  <= final_pair;
            r_out.dropped   <= r_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/key_value_pair_sorter_tb.sv =====
// Self-checking testbench for the key-value pair sorter: batches of pairs in, sorted pairs out.
// Depends on kvps_pkg and key_value_pair_sorter; expected transactions come from an
// insertion-sort predictor that is updated on every accepted input transaction.
module key_value_pair_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvps_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 120;
    localparam int RANDOM_PAIRS = 410;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    t_in  pair_queue[$];
    t_out sorted_queue[$];

    logic [31:0] held_key[MAX_PAIRS];
    logic [31:0] held_value[MAX_PAIRS];
    int   held_count = 0;
    bit   held_overflow = 1'b0;

    int fail_count = 0;
    int pairs_accepted = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    key_value_pair_sorter i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #2 clk = ~clk;

    function automatic void absorb_pair(t_in p);
        int pos;
        t_out r;
        if (held_count < MAX_PAIRS) begin
            pos = held_count;
            while (pos > 0 && held_value[pos - 1] > p.pair_value) begin
                held_key[pos] = held_key[pos - 1];
                held_value[pos] = held_value[pos - 1];
                pos--;
            end
            held_key[pos] = p.pair_key;
            held_value[pos] = p.pair_value;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (p.last_in) begin
            for (int k = 0; k < held_count; k++) begin
                r.out_key = held_key[k];
                r.out_value = held_value[k];
                r.last_out = (k + 1 == held_count);
                r.dropped = held_overflow;
                sorted_queue.push_back(r);
            end
            held_count = 0;
            held_overflow = 1'b0;
        end
    endfunction

    function automatic void add_pair(logic [31:0] key, logic [31:0] value, logic last);
        t_in p;
        p.pair_key = key;
        p.pair_value = value;
        p.last_in = last;
        pair_queue.push_back(p);
    endfunction

    function automatic logic [31:0] pick_value(int flavor);
        logic [31:0] v;
        case (flavor)
            0: begin
                v = $urandom;
            end
            1: begin
                v = $urandom_range(0, 3);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic void add_batch(int size);
        int flavor;
        flavor = $urandom_range(0, 2);
        for (int k = 0; k < size; k++) begin
            add_pair($urandom, pick_value(flavor), k == size - 1);
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_pair(in_data);
                pairs_accepted <= pairs_accepted + 1;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pair_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= pair_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && pairs_accepted >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= (rx_cycle % 5 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (sorted_queue.size() == 0) begin
                $error("unexpected output transaction: key %h value %h",
                       out_data.out_key, out_data.out_value);
                fail_count++;
            end else begin
                want = sorted_queue.pop_front();
                if (out_data.out_key !== want.out_key) begin
                    $error("out_key: expected %h, actual %h", want.out_key, out_data.out_key);
                    fail_count++;
                end
                if (out_data.out_value !== want.out_value) begin
                    $error("out_value: expected %h, actual %h",
                           want.out_value, out_data.out_value);
                    fail_count++;
                end
                if (out_data.last_out !== want.last_out) begin
                    $error("last_out: expected %b, actual %b", want.last_out, out_data.last_out);
                    fail_count++;
                end
                if (out_data.dropped !== want.dropped) begin
                    $error("dropped: expected %b, actual %b", want.dropped, out_data.dropped);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("key_value_pair_sorter_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int batch;
        int size;

        add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
        add_pair(32'h8000_0000, 32'h0000_0001, 1'b0);
        add_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        add_pair(32'h5555_AAAA, 32'h7FFF_FFFF, 1'b1);

        add_pair(32'd1, 32'd5, 1'b0);
        add_pair(32'd2, 32'd3, 1'b0);
        add_pair(32'd3, 32'd5, 1'b0);
        add_pair(32'd4, 32'd3, 1'b0);
        add_pair(32'd5, 32'd5, 1'b0);
        add_pair(32'd6, 32'd0, 1'b1);

        for (int k = 0; k < 4; k++) begin
            add_pair(32'h100 + k, 32'h10 * k, k == 3);
        end
        for (int k = 0; k < 4; k++) begin
            add_pair(32'hA0 + k, 32'hFFFF_FFFF, k == 3);
        end

        batch = 0;
        size = 0;
        while (size < RANDOM_PAIRS) begin
            case (batch)
                2: add_batch(MAX_PAIRS);
                6: add_batch(MAX_PAIRS + 1);
                11: add_batch(MAX_PAIRS + 2);
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_batch($urandom_range(25, 50));
                    end else begin
                        add_batch($urandom_range(1, 12));
                    end
                end
            endcase
            size = pair_queue.size() - 21;
            batch++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do begin
            @(posedge clk);
        end while (pair_queue.size() != 0 || in_valid);
        while (sorted_queue.size() != 0) begin
            @(posedge clk);
        end
        repeat (2 * MAX_PAIRS + 10) @(posedge clk);

        if (fail_count == 0) begin
            $display("key_value_pair_sorter_tb: clean");
        end else begin
            $display("key_value_pair_sorter_tb: errors");
        end
        $finish;
    end
endmodule
